// File: sv/scb_rd_pkg.sv
// ----------------------------------------------------------------------------
// scb_rd_pkg
// Shared types and constants for the record decompressor.
// ----------------------------------------------------------------------------
package scb_rd_pkg;

    localparam int RUN_W      = 10;   // run_length / record_length width
    localparam int FIFO_DEPTH = 4;    // result queue entries

    // record kinds as sampled with the descriptor
    localparam logic [1:0] KIND_PUNCH   = 2'd1;
    localparam logic [1:0] KIND_CONSOLE = 2'd2;

    localparam logic [7:0] PRINT_BLANK   = 8'h20;
    localparam logic [7:0] PUNCH_BLANK   = 8'h40;
    localparam logic [7:0] NEWLINE       = 8'h0A;
    localparam logic [7:0] DESC_SPACE_NL = 8'h91;
    localparam logic [3:0] DESC_LINES_HI = 4'h8;

    typedef enum logic [2:0] {
        PH_DESC   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SCB    = 3'd2,
        PH_COPY   = 3'd3,
        PH_REPEAT = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ITEM_DATA = 2'd0,
        ITEM_TERM = 2'd1,
        ITEM_EOF  = 2'd2
    } t_item_kind;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [RUN_W-1:0] run_length;
        t_item_kind       item_kind;
        logic             last;
        logic [RUN_W-1:0] record_length;
        logic             overflow;
    } t_result;

    // up to two results written into the queue per processed byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_result(
        input logic [7:0]       byte_val,
        input logic [RUN_W-1:0] len,
        input t_item_kind       kind,
        input logic [RUN_W-1:0] rlen,
        input logic             ovf
    );
        t_result r;
        r.out_byte      = byte_val;
        r.run_length    = len;
        r.item_kind     = kind;
        r.last          = 1'b0;
        r.record_length = rlen;
        r.overflow      = ovf;
        return r;
    endfunction

endpackage

// File: sv/scb_rd_if.sv
// ----------------------------------------------------------------------------
// scb_rd_if
// Valid/ready channels for received bytes and decompressed runs.
// ----------------------------------------------------------------------------
interface scb_rd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic [1:0] record_kind;

    modport source (output valid, output in_byte, output record_kind, input ready);
    modport sink   (input valid, input in_byte, input record_kind, output ready);
endinterface

interface scb_rd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [9:0] run_length;
    logic [1:0] item_kind;
    logic       last;
    logic [9:0] record_length;
    logic       overflow;

    modport source (
        output valid, output out_byte, output run_length, output item_kind,
        output last, output record_length, output overflow, input ready
    );
    modport sink (
        input valid, input out_byte, input run_length, input item_kind,
        input last, input record_length, input overflow, output ready
    );
endinterface

// File: sv/scb_record_decompressor.sv
// Path: an accepted byte is held in the input register, decoded from it, and its
//   runs are written into the result queue, which offers the first run to the sink.
// Throughput: one byte per cycle while the queue has room; a stalled sink holds it.
//   The rate is set by the four-entry result queue, which drains one run a cycle.
// Reset (synchronous, i_rst_n low): record state returns to waiting for a
//   descriptor and the input register and result queue are emptied.
// ----------------------------------------------------------------------------
// scb_record_decompressor
// Expands string-control-byte compressed print, punch and console records into
// byte runs, one received byte per transaction.
// ----------------------------------------------------------------------------
module scb_record_decompressor import scb_rd_pkg::*; #(
    parameter int MAX_RECORD = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scb_rd_in_if.sink     i_in,
    scb_rd_out_if.source  o_out
);

    // Runs produced by one decoded byte (zero, one or two of them).
    t_push w_push;
    // Queue has space for the worst case of two runs, so the core may advance.
    logic  w_room;

    // Core: holds the accepted byte, walks the record phases (descriptor,
    // control byte, copy, repeat, skip to end of file), keeps printer blanks
    // as a count and tracks the saturating record length.
    scb_rd_core #(
        .MAX_RECORD (MAX_RECORD)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    // Result queue: decouples the sink so that a stalled run does not stop
    // the next byte from being taken.
    scb_rd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule

// File: sv/scb_rd_core.sv
// ----------------------------------------------------------------------------
// scb_rd_core
// Input register, record state and run generation for one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
module scb_rd_core import scb_rd_pkg::*; #(
    parameter int MAX_RECORD = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scb_rd_in_if.sink    i_in,
    input  logic         i_room,
    output t_push        o_push
);

    localparam int LW = $clog2(MAX_RECORD + 1);
    localparam int SW = LW + 2;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_RECORD);
    localparam logic [SW-1:0] MAX_S = SW'(MAX_RECORD);

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic [1:0] r_kind_in;

    // record state
    t_phase        r_phase, n_phase;
    logic [1:0]    r_kind, n_kind;
    logic [7:0]    r_desc, n_desc;
    logic [5:0]    r_copy_rem, n_copy_rem;
    logic [4:0]    r_rep_cnt, n_rep_cnt;
    logic [LW-1:0] r_pend, n_pend;
    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;

    logic       fire;
    logic       is_zero, is_copy, is_blank, is_rep;
    logic       dr_en, term_en, eof_en, load_en;
    logic [7:0] dr_byte;
    logic [5:0] dr_n;
    logic       printer, hold, flush;
    logic [SW-1:0]    psum, lsum;
    logic [RUN_W-1:0] len10;
    t_push      push;

    assign fire       = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || fire;

    assign is_zero  = (r_byte == 8'h00);
    assign is_copy  = (r_byte[7:6] == 2'b11);
    assign is_blank = (r_byte[7:5] == 3'b100);
    assign is_rep   = (r_byte[7:5] == 3'b101);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte    <= i_in.in_byte;
            r_kind_in <= i_in.record_kind;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase) inside
            PH_FIRST, PH_SCB: begin
                if (is_zero)        n_phase = PH_DESC;
                else if (is_copy)   n_phase = (r_byte[5:0] != 6'd0) ? PH_COPY : PH_SCB;
                else if (is_blank)  n_phase = PH_SCB;
                else if (is_rep)    n_phase = PH_REPEAT;
                else                n_phase = PH_SKIP;
            end
            PH_COPY:   n_phase = ((r_copy_rem - 6'd1) == 6'd0) ? PH_SCB : PH_COPY;
            PH_REPEAT: n_phase = PH_SCB;
            PH_SKIP:   n_phase = is_zero ? PH_DESC : PH_SKIP;
            default:   n_phase = PH_FIRST;
        endcase
    end

    // per-phase actions
    always_comb begin
        dr_en      = 1'b0;
        dr_byte    = r_byte;
        dr_n       = 6'd1;
        term_en    = 1'b0;
        eof_en     = 1'b0;
        load_en    = 1'b0;
        n_copy_rem = r_copy_rem;
        n_rep_cnt  = r_rep_cnt;
        unique case (r_phase) inside
            PH_FIRST, PH_SCB: begin
                if (is_zero) begin
                    eof_en  = (r_phase == PH_FIRST);
                    term_en = (r_phase == PH_SCB);
                end else if (is_copy) begin
                    n_copy_rem = r_byte[5:0];
                end else if (is_blank) begin
                    dr_en   = 1'b1;
                    dr_byte = (r_kind == KIND_PUNCH) ? PUNCH_BLANK : PRINT_BLANK;
                    dr_n    = {1'b0, r_byte[4:0]};
                end else if (is_rep) begin
                    n_rep_cnt = r_byte[4:0];
                end
            end
            PH_COPY: begin
                dr_en      = 1'b1;
                n_copy_rem = r_copy_rem - 6'd1;
            end
            PH_REPEAT: begin
                dr_en     = 1'b1;
                dr_n      = {1'b0, r_rep_cnt};
                n_rep_cnt = 5'd0;
            end
            PH_SKIP: begin
                eof_en = is_zero;
            end
            default: begin
                load_en    = 1'b1;
                n_copy_rem = 6'd0;
                n_rep_cnt  = 5'd0;
            end
        endcase
    end

    // runs, blank holding and length count
    assign printer = !(r_kind == KIND_PUNCH || r_kind == KIND_CONSOLE);
    assign hold    = printer && (dr_byte == PRINT_BLANK);
    assign flush   = printer && (r_pend != '0) && !hold;
    assign psum    = SW'(r_pend) + SW'(dr_n);
    assign lsum    = SW'(r_len) + (flush ? SW'(r_pend) : SW'(0)) + SW'(dr_n);
    assign len10   = RUN_W'(r_len);

    always_comb begin
        n_pend   = r_pend;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_desc   = r_desc;
        n_kind   = r_kind;
        push.cnt = 2'd0;
        push.r0  = '0;
        push.r1  = '0;
        if (load_en) begin
            n_desc = r_byte;
            n_kind = r_kind_in;
            n_pend = '0;
            n_len  = '0;
            n_ovf  = 1'b0;
        end
        if (dr_en && dr_n != 6'd0) begin
            if (hold) begin
                n_pend = (psum > MAX_S) ? MAX_L : psum[LW-1:0];
            end else begin
                if (flush) begin
                    push.r0  = mk_result(PRINT_BLANK, RUN_W'(r_pend), ITEM_DATA, '0, 1'b0);
                    push.r1  = mk_result(dr_byte, RUN_W'(dr_n), ITEM_DATA, '0, 1'b0);
                    push.cnt = 2'd2;
                    n_pend   = '0;
                end else begin
                    push.r0  = mk_result(dr_byte, RUN_W'(dr_n), ITEM_DATA, '0, 1'b0);
                    push.cnt = 2'd1;
                end
                if (lsum > MAX_S) begin
                    n_len = MAX_L;
                    n_ovf = 1'b1;
                end else begin
                    n_len = lsum[LW-1:0];
                end
            end
        end
        if (eof_en) begin
            push.r0  = mk_result(8'h00, '0, ITEM_EOF, '0, 1'b0);
            push.cnt = 2'd1;
        end
        if (term_en) begin
            push.cnt = 2'd1;
            unique case (r_kind)
                KIND_PUNCH:   push.r0 = mk_result(8'h00, '0, ITEM_TERM, len10, r_ovf);
                KIND_CONSOLE: push.r0 = mk_result(NEWLINE, RUN_W'(1), ITEM_TERM, len10, r_ovf);
                default: begin
                    n_pend = '0;
                    if (r_desc[7:4] == DESC_LINES_HI) begin
                        push.r0 = mk_result(NEWLINE, RUN_W'(r_desc[1:0]), ITEM_TERM,
                                            len10, r_ovf);
                    end else if (r_desc == DESC_SPACE_NL) begin
                        push.r0  = mk_result(PRINT_BLANK, RUN_W'(1), ITEM_TERM, len10, r_ovf);
                        push.r1  = mk_result(NEWLINE, RUN_W'(1), ITEM_TERM, len10, r_ovf);
                        push.cnt = 2'd2;
                    end else begin
                        push.r0 = mk_result(NEWLINE, RUN_W'(1), ITEM_TERM, len10, r_ovf);
                    end
                end
            endcase
        end
        push.r0.last = (push.cnt == 2'd1);
        push.r1.last = (push.cnt == 2'd2);
    end

    always_comb begin
        o_push     = push;
        o_push.cnt = fire ? push.cnt : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DESC;
            r_kind     <= 2'd0;
            r_desc     <= 8'h00;
            r_copy_rem <= 6'd0;
            r_rep_cnt  <= 5'd0;
            r_pend     <= '0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_desc     <= n_desc;
            r_copy_rem <= n_copy_rem;
            r_rep_cnt  <= n_rep_cnt;
            r_pend     <= n_pend;
            r_len      <= n_len;
            r_ovf      <= n_ovf;
        end
    end

endmodule

// File: sv/scb_rd_fifo.sv
// ----------------------------------------------------------------------------
// scb_rd_fifo
// Small result queue: takes up to two runs per cycle, hands out one.
// ----------------------------------------------------------------------------
module scb_rd_fifo import scb_rd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push,
    output logic          o_room,
    scb_rd_out_if.source  o_out
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_result       r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          pop;
    t_result       head;

    assign head   = r_mem[r_rd];
    assign pop    = o_out.valid && o_out.ready;
    assign o_room = (r_count <= CW'(FIFO_DEPTH - 2));

    assign o_out.valid         = (r_count != '0);
    assign o_out.out_byte      = head.out_byte;
    assign o_out.run_length    = head.run_length;
    assign o_out.item_kind     = head.item_kind;
    assign o_out.last          = head.last;
    assign o_out.record_length = head.record_length;
    assign o_out.overflow      = head.overflow;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push.cnt);
            r_rd    <= r_rd + PW'(pop);
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
        end
    end

endmodule

// File: sv/scb_rd_checker.sv
// ----------------------------------------------------------------------------
// scb_rd_checker
// Port-level checks on the decompressor's result channel.
// ----------------------------------------------------------------------------
module scb_rd_checker import scb_rd_pkg::*; #(
    parameter int MAX_RECORD = 512
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [7:0]       i_out_byte,
    input logic [RUN_W-1:0] i_run_length,
    input logic [1:0]       i_item_kind,
    input logic             i_last,
    input logic [RUN_W-1:0] i_record_length,
    input logic             i_overflow
);

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_run_length)
            && $stable(i_item_kind) && $stable(i_last))
        else $error("result changed while stalled");

    // end of file stands alone and carries no run
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_item_kind == ITEM_EOF |->
            i_last && i_run_length == '0 && i_out_byte == 8'h00
            && i_record_length == '0 && !i_overflow)
        else $error("bad end of file result");

    // data runs are never empty and carry no length
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_item_kind == ITEM_DATA |->
            i_run_length != '0 && i_record_length == '0 && !i_overflow)
        else $error("bad data run");

    // overflow means the length saturated
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |->
            i_item_kind == ITEM_TERM && i_record_length == RUN_W'(MAX_RECORD))
        else $error("overflow without saturated length");

endmodule

bind scb_record_decompressor scb_rd_checker #(
    .MAX_RECORD (MAX_RECORD)
) u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_run_length    (o_out.run_length),
    .i_item_kind     (o_out.item_kind),
    .i_last          (o_out.last),
    .i_record_length (o_out.record_length),
    .i_overflow      (o_out.overflow)
);

// File: tb/sv/scb_rd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scb_rd_tb_pkg
// String control byte codes and record kinds shared by the stimulus and the
// checker of the record decompressor bench.
// ----------------------------------------------------------------------------
package scb_rd_tb_pkg;

    // control byte prefixes, bits 7:6
    localparam logic [1:0] TAG_COPY = 2'b11;
    localparam logic [1:0] TAG_FILL = 2'b10;   // bit 5 splits blanks / repeat

    // control bytes with a zero count field
    localparam logic [7:0] CTL_END     = 8'h00;
    localparam logic [7:0] CTL_COPY    = 8'hC0;
    localparam logic [7:0] CTL_BLANKS  = 8'h80;
    localparam logic [7:0] CTL_REPEAT  = 8'hA0;
    localparam logic [7:0] CTL_BAD_MAX = 8'h7F;  // 01..7F are all unknown

    localparam int COPY_MAX = 63;
    localparam int FILL_MAX = 31;

    localparam logic [1:0] KIND_PRINTER = 2'd0;
    localparam logic [1:0] KIND_SPARE   = 2'd3;  // unused code, decodes as printer

endpackage

// File: tb/sv/scb_record_decompressor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scb_record_decompressor_checker
// Watches both channels, predicts the runs of every accepted byte and compares
// each accepted run with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module scb_record_decompressor_checker import scb_rd_pkg::*, scb_rd_tb_pkg::*; #(
    parameter int MAX_RECORD = 512
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    scb_rd_in_if  i_in,
    scb_rd_out_if i_out,
    output int    o_fail_count,
    output int    o_pending
);

    // decoder state
    t_phase     phase;
    logic [1:0] kind_held;
    logic [7:0] desc_held;
    logic [5:0] copy_left;
    logic [4:0] repeat_n;
    int         held_blanks;
    int         rec_len;
    logic       rec_ovf;

    t_result    staged[3];
    int         staged_n;
    t_result    expected_runs[$];
    t_result    want;
    int         failures = 0;

    task automatic stage_run(input logic [7:0] value, input int len,
                             input t_item_kind kind, input int rlen, input logic ovf);
        if (staged_n < 3) begin
            staged[staged_n].out_byte      = value;
            staged[staged_n].run_length    = len[RUN_W-1:0];
            staged[staged_n].item_kind     = kind;
            staged[staged_n].last          = 1'b0;
            staged[staged_n].record_length = rlen[RUN_W-1:0];
            staged[staged_n].overflow      = ovf;
            staged_n++;
        end
    endtask

    task automatic bump_length(input int n);
        rec_len = rec_len + n;
        if (rec_len > MAX_RECORD) begin
            rec_len = MAX_RECORD;
            rec_ovf = 1'b1;
        end
    endtask

    // printer mode holds blanks back until a non-blank follows
    task automatic emit_data(input logic [7:0] value, input int n);
        logic printer;
        printer = (kind_held != KIND_PUNCH) && (kind_held != KIND_CONSOLE);
        if (n == 0)
            return;
        if (printer && value == PRINT_BLANK) begin
            held_blanks = (held_blanks + n > MAX_RECORD) ? MAX_RECORD : held_blanks + n;
            return;
        end
        if (printer && held_blanks != 0) begin
            stage_run(PRINT_BLANK, held_blanks, ITEM_DATA, 0, 1'b0);
            bump_length(held_blanks);
            held_blanks = 0;
        end
        stage_run(value, n, ITEM_DATA, 0, 1'b0);
        bump_length(n);
    endtask

    task automatic decode_control(input logic [7:0] b);
        if (b[7:6] == TAG_COPY) begin
            copy_left = b[5:0];
            phase     = (b[5:0] != 6'd0) ? PH_COPY : PH_SCB;
        end else if (b[7:6] == TAG_FILL) begin
            if (b[5]) begin
                repeat_n = b[4:0];
                phase    = PH_REPEAT;
            end else begin
                emit_data((kind_held == KIND_PUNCH) ? PUNCH_BLANK : PRINT_BLANK, int'(b[4:0]));
                phase = PH_SCB;
            end
        end else if (b == CTL_END) begin
            if (kind_held == KIND_PUNCH) begin
                stage_run(8'h00, 0, ITEM_TERM, rec_len, rec_ovf);
            end else if (kind_held == KIND_CONSOLE) begin
                stage_run(NEWLINE, 1, ITEM_TERM, rec_len, rec_ovf);
            end else begin
                held_blanks = 0;    // trailing blanks dropped
                if (desc_held[7:4] == DESC_LINES_HI) begin
                    stage_run(NEWLINE, int'(desc_held[1:0]), ITEM_TERM, rec_len, rec_ovf);
                end else if (desc_held == DESC_SPACE_NL) begin
                    stage_run(PRINT_BLANK, 1, ITEM_TERM, rec_len, rec_ovf);
                    stage_run(NEWLINE, 1, ITEM_TERM, rec_len, rec_ovf);
                end else begin
                    stage_run(NEWLINE, 1, ITEM_TERM, rec_len, rec_ovf);
                end
            end
            phase = PH_DESC;
        end else begin
            phase = PH_SKIP;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic [1:0] kind);
        staged_n = 0;
        case (phase)
            PH_FIRST: begin
                if (b == CTL_END) begin
                    stage_run(8'h00, 0, ITEM_EOF, 0, 1'b0);
                    phase = PH_DESC;
                end else begin
                    decode_control(b);
                end
            end
            PH_SCB: begin
                decode_control(b);
            end
            PH_COPY: begin
                emit_data(b, 1);
                copy_left = copy_left - 6'd1;
                if (copy_left == 6'd0)
                    phase = PH_SCB;
            end
            PH_REPEAT: begin
                emit_data(b, int'(repeat_n));
                repeat_n = 5'd0;
                phase    = PH_SCB;
            end
            PH_SKIP: begin
                if (b == CTL_END) begin
                    stage_run(8'h00, 0, ITEM_EOF, 0, 1'b0);
                    phase = PH_DESC;
                end
            end
            default: begin
                desc_held   = b;
                kind_held   = kind;
                copy_left   = 6'd0;
                repeat_n    = 5'd0;
                held_blanks = 0;
                rec_len     = 0;
                rec_ovf     = 1'b0;
                phase       = PH_FIRST;
            end
        endcase
        if (staged_n > 0)
            staged[staged_n-1].last = 1'b1;
        for (int i = 0; i < staged_n; i++)
            expected_runs.push_back(staged[i]);
    endtask

    function void check_field(input string name, input int unsigned exp_val,
                              input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase       = PH_DESC;
            kind_held   = 2'd0;
            desc_held   = 8'd0;
            copy_left   = 6'd0;
            repeat_n    = 5'd0;
            held_blanks = 0;
            rec_len     = 0;
            rec_ovf     = 1'b0;
            expected_runs.delete();
        end else begin
            // runs first: a byte taken at this edge cannot have its runs out yet
            if (i_out.valid && i_out.ready) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected run: out_byte %0d run_length %0d item_kind %0d",
                           i_out.out_byte, i_out.run_length, i_out.item_kind);
                    failures++;
                end else begin
                    want = expected_runs.pop_front();
                    check_field("out_byte", want.out_byte, i_out.out_byte);
                    check_field("run_length", want.run_length, i_out.run_length);
                    check_field("item_kind", want.item_kind, i_out.item_kind);
                    check_field("last", want.last, i_out.last);
                    check_field("record_length", want.record_length, i_out.record_length);
                    check_field("overflow", want.overflow, i_out.overflow);
                end
            end
            if (i_in.valid && i_in.ready)
                decode_byte(i_in.in_byte, i_in.record_kind);
        end
        o_fail_count <= failures;
        o_pending    <= expected_runs.size();
    end

endmodule

// File: tb/sv/scb_record_decompressor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scb_record_decompressor_test
// Drives compressed records into the decompressor: a directed set covering
// each control byte and record ending, then random records that are mostly
// well formed, with long records that saturate the length and broken ones
// that fall into the skip-to-end-of-file path. Both channels idle at random.
// ----------------------------------------------------------------------------
module scb_record_decompressor_test import scb_rd_pkg::*, scb_rd_tb_pkg::*;;

    localparam int MAX_RECORD   = 512;
    localparam int MAX_GAP      = 19;      // longest idle draw on either side
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 60;      // watch for stray runs after the last one
    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run

    logic i_clk = 1'b0;
    logic i_rst_n;

    scb_rd_in_if  in_ch ();
    scb_rd_out_if out_ch ();

    int   fail_count;
    int   pending;
    int   bytes_sent  = 0;
    int   cycle_count = 0;
    int   random_goal;

    // per-record switches for back-to-back stretches with no idle cycles
    logic in_quiet  = 1'b0;
    logic out_quiet = 1'b0;

    scb_record_decompressor #(.MAX_RECORD(MAX_RECORD)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    scb_record_decompressor_checker #(.MAX_RECORD(MAX_RECORD)) run_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a lost run ends up here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Sink side: every run waits out a random stall. Ready only drops again in
    // the step where the previous run was taken, and stays high while waiting.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // One byte transaction. Valid stays high across back-to-back bytes; it
    // only drops when an idle gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic [1:0] kind);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.record_kind <= kind;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // Record body byte: the kind field is only sampled with the descriptor,
    // so it carries noise everywhere else.
    task automatic send_body(input logic [7:0] b);
        send_byte(b, 2'($urandom_range(0, 3)));
    endtask

    // Blanks often, so the printer blank holding sees real traffic.
    function automatic logic [7:0] random_data();
        if ($urandom_range(0, 2) == 0)
            return PRINT_BLANK;
        return 8'($urandom_range(0, 255));
    endfunction

    // Newline-count form, space-newline form, or anything at all.
    function automatic logic [7:0] pick_descriptor();
        case ($urandom_range(0, 3))
            0:       return {DESC_LINES_HI, 4'($urandom_range(0, 15))};
            1:       return DESC_SPACE_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed control groups: copy, blank fill, repeat.
    task automatic send_groups(input int count);
        int len;
        repeat (count) begin
            case ($urandom_range(0, 2))
                0: begin
                    // mostly short copies, now and then up to the full count field
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, COPY_MAX)
                                                      : $urandom_range(0, 5);
                    send_body(CTL_COPY | 8'(len));
                    repeat (len) send_body(random_data());
                end
                1: begin
                    send_body(CTL_BLANKS | 8'($urandom_range(0, FILL_MAX)));
                end
                default: begin
                    send_body(CTL_REPEAT | 8'($urandom_range(0, FILL_MAX)));
                    send_body(random_data());
                end
            endcase
        end
    endtask

    // Enough full-count fills to pass MAX_RECORD: the length saturates and
    // flags overflow, and in printer mode the held blank count saturates too.
    // A final copy of a non-blank byte flushes whatever blanks are held.
    task automatic send_long_record(input logic [1:0] kind);
        send_byte(pick_descriptor(), kind);
        repeat ($urandom_range(17, 20)) begin
            if ($urandom_range(0, 1) == 1) begin
                send_body(CTL_REPEAT | 8'(FILL_MAX));
                send_body(random_data());
            end else begin
                send_body(CTL_BLANKS | 8'(FILL_MAX));
            end
        end
        send_body(CTL_COPY | 8'd1);
        send_body(8'($urandom_range(8'h21, 8'hFF)));
        send_body(CTL_END);
    endtask

    // One random record. Every shape ends on a zero byte, so the stream
    // always comes back to a descriptor.
    task automatic send_record();
        int         pick;
        logic [1:0] kind;
        pick      = $urandom_range(0, 99);
        kind      = 2'($urandom_range(0, 3));
        in_quiet  = ($urandom_range(0, 4) == 0);
        out_quiet = ($urandom_range(0, 4) == 0);
        if (pick < 5) begin
            send_long_record(kind);
        end else begin
            send_byte(pick_descriptor(), kind);
            if (pick >= 30) begin
                send_groups($urandom_range(1, 6));
            end else if (pick >= 15) begin
                // broken: unknown control byte, then noise up to the zero
                send_groups($urandom_range(0, 3));
                send_body(8'($urandom_range(1, CTL_BAD_MAX)));
                repeat ($urandom_range(0, 5)) send_body(8'($urandom_range(1, 255)));
            end
            // pick below 15 leaves the zero right after the descriptor
            send_body(CTL_END);
        end
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= 8'h00;
        in_ch.record_kind <= KIND_PRINTER;
        i_rst_n           <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // printer, zero newlines: held blanks flushed ahead of a data byte
        // (two runs from one byte), trailing blanks dropped
        send_byte(8'h80, KIND_PRINTER);
        send_body(CTL_BLANKS | 8'd2);
        send_body(CTL_COPY | 8'd1);
        send_body(8'hFF);
        send_body(CTL_BLANKS | 8'd5);
        send_body(CTL_END);

        // punch: repeat of a zero byte, full fill of punch blanks, length at end
        send_byte(DESC_SPACE_NL, KIND_PUNCH);
        send_body(CTL_REPEAT | 8'd3);
        send_body(8'h00);
        send_body(CTL_BLANKS | 8'(FILL_MAX));
        send_body(CTL_END);

        // console: empty copy, zero repeat still eats its byte, blank is data
        send_byte(8'hFF, KIND_CONSOLE);
        send_body(CTL_COPY);
        send_body(CTL_REPEAT);
        send_body(8'h55);
        send_body(CTL_COPY | 8'd1);
        send_body(PRINT_BLANK);
        send_body(CTL_END);

        // spare kind decodes as printer; space then newline terminator
        send_byte(DESC_SPACE_NL, KIND_SPARE);
        send_body(CTL_COPY | 8'd1);
        send_body(8'h41);
        send_body(CTL_END);

        // zero straight after the descriptor reports end of file
        send_byte(8'h00, KIND_PRINTER);
        send_body(CTL_END);

        // unknown control byte: skip to the next zero, end of file
        send_byte(8'h10, KIND_PRINTER);
        send_body(CTL_BAD_MAX);
        send_body(8'h33);
        send_body(CTL_END);

        // random part, opened by one record long enough to saturate
        random_goal = bytes_sent + RANDOM_ITEMS;
        send_long_record(2'($urandom_range(0, 3)));
        while (bytes_sent < random_goal)
            send_record();

        in_ch.valid <= 1'b0;
        out_quiet   = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
